>>> design/nvms_pkg.sv
package nvms_pkg;

   localparam int DIM_BITS  = 14;
   localparam int RATE_BITS = 10;
   localparam int PIX_BITS  = 2 * DIM_BITS;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [DIM_BITS-1:0]  REQ_WIDTH_RST  = DIM_BITS'(1280);
   localparam logic [DIM_BITS-1:0]  REQ_HEIGHT_RST = DIM_BITS'(720);
   localparam logic [RATE_BITS-1:0] REQ_FPS_RST    = RATE_BITS'(30);

   localparam logic [CSR_IDX_BITS-1:0] CSR_REQ_WIDTH  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_REQ_HEIGHT = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_REQ_FPS    = CSR_IDX_BITS'(2);

   typedef struct packed {
      logic [DIM_BITS-1:0]  mode_width;
      logic [DIM_BITS-1:0]  mode_height;
      logic [RATE_BITS-1:0] mode_fps;
      logic                 has_mode;
      logic                 last_mode;
   } nvms_req_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]  sel_width;
      logic [DIM_BITS-1:0]  sel_height;
      logic [RATE_BITS-1:0] sel_fps;
      logic                 used_request;
   } nvms_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_REQ,
      ST_MUL_MODE,
      ST_JUDGE_HI,
      ST_JUDGE_MAX,
      ST_FINISH
   } nvms_state_type;

   typedef struct packed {
      logic idle;
      logic mul_req;
      logic mul_mode;
      logic judge_hi;
      logic judge_max;
      logic finish;
   } nvms_ctrl_type;

   typedef struct packed {
      logic [PIX_BITS-1:0]  cand_pix;
      logic [PIX_BITS-1:0]  held_pix;
      logic [RATE_BITS-1:0] cand_rate;
      logic [RATE_BITS-1:0] held_rate;
      logic [RATE_BITS-1:0] target_rate;
      logic                 want_small;
      logic                 held_empty;
   } nvms_judge_type;

endpackage

>>> design/nearest_video_mode_select.sv
// Nearest video mode selection.
// Modes arrive one per transaction on the req_ channel (width, height, rate,
// has_mode, last_mode). The block keeps the best mode at or above the
// requested pixel count and the best mode of the largest pixel count, and on
// the last transaction of a list returns one result on the rsp_ channel.
// A list without any mode (ended by a last transaction without one) returns the request.
// The request is written on the csr_ channel (index 0 width, 1 height,
// 2 rate); csr_ready is always high and writes belong between lists.
// A mode goes through these steps: accept, then two passes through the one
// shared multiplier for request and mode pixel counts, then two passes
// through the shared compare unit for the two candidate sets. No new item
// is accepted until these steps are done. An item without a mode is only
// accepted; after a last item the result is registered in a finish step.
// The result waits in an output register while rsp_stall is high; the next
// list can start meanwhile, and the block stalls only when a further result
// is ready before the held one is taken.
// Reset clears the list state, drops rsp_valid and loads the request
// registers with 1280 x 720 at 30 frames per second.
module nearest_video_mode_select (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  nvms_pkg::nvms_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output nvms_pkg::nvms_rsp_type                rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nvms_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [nvms_pkg::DIM_BITS-1:0]         csr_data
);

   localparam int DB = nvms_pkg::DIM_BITS;
   localparam int RB = nvms_pkg::RATE_BITS;
   localparam int PB = nvms_pkg::PIX_BITS;

   nvms_pkg::nvms_ctrl_type  ctrl;
   nvms_pkg::nvms_judge_type judge;
   nvms_pkg::nvms_req_type   item_ff;
   nvms_pkg::nvms_rsp_type   rsp_ff;
   nvms_pkg::nvms_rsp_type   rsp_in;

   logic [DB-1:0] req_width_ff, req_height_ff;
   logic [RB-1:0] req_fps_ff;

   logic          any_seen_ff, hi_valid_ff, rsp_valid_ff, rsp_valid_in;
   logic [PB-1:0] hi_pixels_ff, max_pixels_ff, rp_ff, product;
   logic [DB-1:0] hi_width_ff, hi_height_ff, max_width_ff, max_height_ff;
   logic [RB-1:0] hi_rate_ff, max_rate_ff;

   logic          req_fire, out_free, better, hi_upd, max_upd;
   logic [DB-1:0] mul_a, mul_b;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = !ctrl.idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   nvms_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_has   (req_data.has_mode),
      .req_last  (req_data.last_mode),
      .item_last (item_ff.last_mode),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   assign mul_a = ctrl.mul_req ? req_width_ff  : item_ff.mode_width;
   assign mul_b = ctrl.mul_req ? req_height_ff : item_ff.mode_height;

   nvms_mul u_mul (
      .clock      (clock),
      .load       (ctrl.mul_req || ctrl.mul_mode),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .product_ff (product)
   );

   // one compare unit, pointed at the above-request set or the largest set
   always_comb begin
      judge.cand_pix    = product;
      judge.cand_rate   = item_ff.mode_fps;
      judge.target_rate = req_fps_ff;
      if (ctrl.judge_hi) begin
         judge.held_pix   = hi_pixels_ff;
         judge.held_rate  = hi_rate_ff;
         judge.want_small = 1'b1;
         judge.held_empty = !hi_valid_ff;
      end else begin
         judge.held_pix   = max_pixels_ff;
         judge.held_rate  = max_rate_ff;
         judge.want_small = 1'b0;
         judge.held_empty = !any_seen_ff;
      end
   end

   nvms_judge u_judge (
      .judge  (judge),
      .better (better)
   );

   assign hi_upd  = ctrl.judge_hi && (product >= rp_ff) && better;
   assign max_upd = ctrl.judge_max && better;

   always_comb begin
      if (!any_seen_ff) begin
         rsp_in.sel_width    = req_width_ff;
         rsp_in.sel_height   = req_height_ff;
         rsp_in.sel_fps      = req_fps_ff;
         rsp_in.used_request = 1'b1;
      end else if (hi_valid_ff) begin
         rsp_in.sel_width    = hi_width_ff;
         rsp_in.sel_height   = hi_height_ff;
         rsp_in.sel_fps      = hi_rate_ff;
         rsp_in.used_request = 1'b0;
      end else begin
         rsp_in.sel_width    = max_width_ff;
         rsp_in.sel_height   = max_height_ff;
         rsp_in.sel_fps      = max_rate_ff;
         rsp_in.used_request = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_width_ff  <= nvms_pkg::REQ_WIDTH_RST;
         req_height_ff <= nvms_pkg::REQ_HEIGHT_RST;
         req_fps_ff    <= nvms_pkg::REQ_FPS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            nvms_pkg::CSR_REQ_WIDTH:  req_width_ff  <= csr_data;
            nvms_pkg::CSR_REQ_HEIGHT: req_height_ff <= csr_data;
            nvms_pkg::CSR_REQ_FPS:    req_fps_ff    <= csr_data[RB-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_seen_ff  <= 1'b0;
         hi_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.finish) begin
            any_seen_ff <= 1'b0;
            hi_valid_ff <= 1'b0;
         end else begin
            if (hi_upd) begin
               hi_valid_ff <= 1'b1;
            end
            if (ctrl.judge_max) begin
               any_seen_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_data;
      end
      if (ctrl.mul_mode) begin
         rp_ff <= product;
      end
      if (hi_upd) begin
         hi_pixels_ff <= product;
         hi_width_ff  <= item_ff.mode_width;
         hi_height_ff <= item_ff.mode_height;
         hi_rate_ff   <= item_ff.mode_fps;
      end
      if (max_upd) begin
         max_pixels_ff <= product;
         max_width_ff  <= item_ff.mode_width;
         max_height_ff <= item_ff.mode_height;
         max_rate_ff   <= item_ff.mode_fps;
      end
      if (ctrl.finish) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> design/nvms_mul.sv
module nvms_mul (
   input  logic                           clock,
   input  logic                           load,
   input  logic [nvms_pkg::DIM_BITS-1:0]  op_a,
   input  logic [nvms_pkg::DIM_BITS-1:0]  op_b,
   output logic [nvms_pkg::PIX_BITS-1:0]  product_ff
);

   logic [nvms_pkg::PIX_BITS-1:0] product_in;

   always_comb begin
      product_in = product_ff;
      if (load) begin
         product_in = nvms_pkg::PIX_BITS'(op_a) * nvms_pkg::PIX_BITS'(op_b);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

>>> design/nvms_judge.sv
module nvms_judge (
   input  nvms_pkg::nvms_judge_type judge,
   output logic                     better
);

   logic [nvms_pkg::RATE_BITS-1:0] gap_cand;
   logic [nvms_pkg::RATE_BITS-1:0] gap_held;
   logic                           rate_win;
   logic                           pix_win;
   logic                           pix_same;

   always_comb begin
      gap_cand = (judge.cand_rate >= judge.target_rate) ?
                 judge.cand_rate - judge.target_rate : judge.target_rate - judge.cand_rate;
      gap_held = (judge.held_rate >= judge.target_rate) ?
                 judge.held_rate - judge.target_rate : judge.target_rate - judge.held_rate;
      // equal distance: a rate at or above the request beats one below it
      rate_win = (gap_cand < gap_held) ||
                 ((gap_cand == gap_held) && (judge.cand_rate >= judge.target_rate) &&
                  (judge.held_rate < judge.target_rate));
      pix_win  = judge.want_small ? (judge.cand_pix < judge.held_pix)
                                  : (judge.cand_pix > judge.held_pix);
      pix_same = judge.cand_pix == judge.held_pix;
      better   = judge.held_empty || pix_win || (pix_same && rate_win);
   end

endmodule

>>> design/nvms_seq.sv
module nvms_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic                   req_has,
   input  logic                   req_last,
   input  logic                   item_last,
   input  logic                   out_free,
   output nvms_pkg::nvms_ctrl_type ctrl
);

   nvms_pkg::nvms_state_type state_ff;
   nvms_pkg::nvms_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nvms_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_has) begin
                  state_in = nvms_pkg::ST_MUL_REQ;
               end else if (req_last) begin
                  state_in = nvms_pkg::ST_FINISH;
               end
            end
         end
         nvms_pkg::ST_MUL_REQ:   state_in = nvms_pkg::ST_MUL_MODE;
         nvms_pkg::ST_MUL_MODE:  state_in = nvms_pkg::ST_JUDGE_HI;
         nvms_pkg::ST_JUDGE_HI:  state_in = nvms_pkg::ST_JUDGE_MAX;
         nvms_pkg::ST_JUDGE_MAX: begin
            state_in = item_last ? nvms_pkg::ST_FINISH : nvms_pkg::ST_IDLE;
         end
         nvms_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = nvms_pkg::ST_IDLE;
            end
         end
         default: state_in = nvms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         nvms_pkg::ST_IDLE:      ctrl.idle      = 1'b1;
         nvms_pkg::ST_MUL_REQ:   ctrl.mul_req   = 1'b1;
         nvms_pkg::ST_MUL_MODE:  ctrl.mul_mode  = 1'b1;
         nvms_pkg::ST_JUDGE_HI:  ctrl.judge_hi  = 1'b1;
         nvms_pkg::ST_JUDGE_MAX: ctrl.judge_max = 1'b1;
         nvms_pkg::ST_FINISH:    ctrl.finish    = out_free;
         default:                ctrl           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nvms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
